// File: rtl/tts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the task tick scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int MAX_TASKS = 16;

    localparam int SLOT_W  = 4;
    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 16;
    localparam int RUN_W   = 8;
    localparam int COUNT_W = 5;
    localparam int MODE_W  = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b1;

    // Scheduling modes.
    localparam logic [MODE_W-1:0] MODE_PRIORITY    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEADLINE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd2;

    // Input actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } sched_state_t;

    // Static part of a table entry; remaining time lives in its own memory.
    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] arrival;
    } task_info_t;

    typedef struct packed {
        logic info_we;
        logic rem_we;
        logic set_valid;
    } store_cmd_t;

endpackage
`default_nettype wire

// File: rtl/tts_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_in_if
// Input channel of the scheduler: load and tick transactions.
// ----------------------------------------------------------------------------
interface tts_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [tts_pkg::SLOT_W-1:0]    slot;
    logic [tts_pkg::ID_W-1:0]      task_id;
    logic [tts_pkg::PRIO_W-1:0]    priority_req;
    logic [tts_pkg::TIME_W-1:0]    deadline;
    logic [tts_pkg::TIME_W-1:0]    arrival;
    logic [tts_pkg::RUN_W-1:0]     run_time;

    modport source (
        output valid, action, slot, task_id, priority_req, deadline, arrival, run_time,
        input  ready
    );

    modport sink (
        input  valid, action, slot, task_id, priority_req, deadline, arrival, run_time,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/tts_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_out_if
// Result channel of the scheduler: one transaction per tick.
// ----------------------------------------------------------------------------
interface tts_out_if;
    logic                          valid;
    logic                          ready;
    logic                          executed;
    logic [tts_pkg::SLOT_W-1:0]    chosen_slot;
    logic [tts_pkg::ID_W-1:0]      chosen_id;
    logic                          completed;
    logic [tts_pkg::TIME_W-1:0]    tick_time;

    modport source (
        output valid, executed, chosen_slot, chosen_id, completed, tick_time,
        input  ready
    );

    modport sink (
        input  valid, executed, chosen_slot, chosen_id, completed, tick_time,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/task_tick_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// task_tick_scheduler_core
// Tick-driven task scheduler: priority, earliest deadline or round robin.
// ----------------------------------------------------------------------------
// A load transaction writes one table slot. A tick transaction scans the
// active slots one per cycle through the table memory, which has one read
// port with a registered output; the chosen entry's remaining time is
// written back in the last scan cycle. The result sits in an output
// register, so loads are accepted while it waits to be taken. The table
// needs no clearing pass: valid bits mark loaded slots.
// ----------------------------------------------------------------------------
module task_tick_scheduler_core #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wr_en,
    input  wire [tts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [tts_pkg::CFG_DATA_W-1:0]      cfg_data,
    tts_in_if.sink                             task_in,
    tts_out_if.source                          result_out
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    // Configuration.
    logic [tts_pkg::MODE_W-1:0]   sched_mode_reg;
    logic [tts_pkg::COUNT_W-1:0]  task_count_reg;

    // Scheduler state.
    tts_pkg::sched_state_t        state_reg, state_next;
    logic [tts_pkg::TIME_W-1:0]   time_reg, time_next;
    logic [AW-1:0]                rot_reg, rot_next;

    // Scan control.
    logic [tts_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [CW-1:0]                n_reg, n_next;
    logic [CW-1:0]                iss_reg, iss_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic [AW-1:0]                pend_slot_reg, pend_slot_next;
    logic [tts_pkg::TIME_W-1:0]   now_reg, now_next;

    // Best candidate so far.
    logic                         found_reg, found_next;
    logic [tts_pkg::TIME_W-1:0]   best_key_reg, best_key_next;
    logic [AW-1:0]                best_slot_reg, best_slot_next;
    logic [tts_pkg::ID_W-1:0]     best_id_reg, best_id_next;
    logic [tts_pkg::RUN_W-1:0]    best_rem_reg, best_rem_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic                         out_exec_reg, out_exec_next;
    logic [tts_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [tts_pkg::ID_W-1:0]     out_id_reg, out_id_next;
    logic                         out_comp_reg, out_comp_next;
    logic [tts_pkg::TIME_W-1:0]   out_time_reg, out_time_next;

    // Table interface.
    tts_pkg::store_cmd_t          st_cmd;
    logic [AW-1:0]                st_wr_addr;
    tts_pkg::task_info_t          st_wr_info;
    logic [tts_pkg::RUN_W-1:0]    st_wr_rem;
    tts_pkg::task_info_t          st_rd_info;
    logic [tts_pkg::RUN_W-1:0]    st_rd_rem;

    logic [CW-1:0]                active_n;
    logic [AW-1:0]                start_slot;
    logic                         slot_in_table;
    logic                         in_fire;
    logic                         cand_elig;
    logic                         cand_better;
    logic [tts_pkg::TIME_W-1:0]   cand_key;

    tts_task_store #(
        .MAX_TASKS (MAX_TASKS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (st_cmd),
        .wr_addr (st_wr_addr),
        .wr_info (st_wr_info),
        .wr_rem  (st_wr_rem),
        .rd_addr (addr_reg),
        .rd_info (st_rd_info),
        .rd_rem  (st_rd_rem)
    );

    assign active_n = (32'(task_count_reg) > 32'(MAX_TASKS)) ? CW'(MAX_TASKS)
                                                             : CW'(task_count_reg);
    assign start_slot    = (CW'(rot_reg) < active_n) ? rot_reg : '0;
    assign slot_in_table = (32'(task_in.slot) < 32'(MAX_TASKS));

    assign task_in.ready = (state_reg == tts_pkg::ST_IDLE);
    assign in_fire       = task_in.valid && task_in.ready;

    assign st_wr_info.task_id      = task_in.task_id;
    assign st_wr_info.priority_req = task_in.priority_req;
    assign st_wr_info.deadline     = task_in.deadline;
    assign st_wr_info.arrival      = task_in.arrival;

    // Candidate evaluation for the entry read in the previous cycle.
    always_comb
    begin
        cand_elig = 1'b0;
        cand_key  = {{(tts_pkg::TIME_W-tts_pkg::PRIO_W){1'b0}}, st_rd_info.priority_req};
        case (mode_reg)
            tts_pkg::MODE_PRIORITY:
            begin
                cand_elig = (st_rd_rem != '0);
            end
            tts_pkg::MODE_DEADLINE:
            begin
                cand_elig = (st_rd_rem != '0) && (st_rd_info.arrival <= now_reg);
                cand_key  = st_rd_info.deadline;
            end
            tts_pkg::MODE_ROUND_ROBIN:
            begin
                cand_elig = (st_rd_rem != '0);
            end
            default:
            begin
                cand_elig = 1'b0;
            end
        endcase
        cand_better = !found_reg
                   || ((mode_reg == tts_pkg::MODE_PRIORITY) && (cand_key > best_key_reg))
                   || ((mode_reg == tts_pkg::MODE_DEADLINE) && (cand_key < best_key_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        rot_next       = rot_reg;
        mode_next      = mode_reg;
        n_next         = n_reg;
        iss_next       = iss_reg;
        addr_next      = addr_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        now_next       = now_reg;
        found_next     = found_reg;
        best_key_next  = best_key_reg;
        best_slot_next = best_slot_reg;
        best_id_next   = best_id_reg;
        best_rem_next  = best_rem_reg;
        out_valid_next = out_valid_reg;
        out_exec_next  = out_exec_reg;
        out_slot_next  = out_slot_reg;
        out_id_next    = out_id_reg;
        out_comp_next  = out_comp_reg;
        out_time_next  = out_time_reg;

        st_cmd     = '0;
        st_wr_addr = AW'(task_in.slot);
        st_wr_rem  = task_in.run_time;

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (task_in.action == tts_pkg::ACT_LOAD)
                    begin
                        if (slot_in_table)
                        begin
                            st_cmd.info_we   = 1'b1;
                            st_cmd.rem_we    = 1'b1;
                            st_cmd.set_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next     = sched_mode_reg;
                        n_next        = active_n;
                        iss_next      = '0;
                        // Priority and deadline scans run from slot 0 so that
                        // ties go to the lowest slot.
                        addr_next     = (sched_mode_reg == tts_pkg::MODE_ROUND_ROBIN)
                                      ? start_slot : '0;
                        pend_vld_next = 1'b0;
                        now_next      = time_reg;
                        found_next    = 1'b0;
                        if (time_reg != tts_pkg::TIME_MAX)
                        begin
                            time_next = time_reg + 1'b1;
                        end
                        state_next = tts_pkg::ST_SCAN;
                    end
                end
            end

            tts_pkg::ST_SCAN:
            begin
                if (pend_vld_reg && cand_elig && cand_better)
                begin
                    found_next     = 1'b1;
                    best_key_next  = cand_key;
                    best_slot_next = pend_slot_reg;
                    best_id_next   = st_rd_info.task_id;
                    best_rem_next  = st_rd_rem;
                end

                if (iss_reg < n_reg)
                begin
                    // The read for addr_reg goes out this cycle.
                    pend_vld_next  = 1'b1;
                    pend_slot_next = addr_reg;
                    iss_next       = iss_reg + 1'b1;
                    addr_next      = ((CW'(addr_reg) + CW'(1)) == n_reg) ? '0
                                                                        : addr_reg + 1'b1;
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end

                if ((iss_reg == n_reg) && !pend_vld_reg)
                begin
                    if (found_reg)
                    begin
                        st_cmd.rem_we = 1'b1;
                        st_wr_addr    = best_slot_reg;
                        st_wr_rem     = best_rem_reg - 1'b1;
                        if (mode_reg == tts_pkg::MODE_ROUND_ROBIN)
                        begin
                            rot_next = ((CW'(best_slot_reg) + CW'(1)) >= n_reg) ? '0
                                                                               : best_slot_reg + 1'b1;
                        end
                    end
                    state_next = tts_pkg::ST_DONE;
                end
            end

            tts_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_exec_next  = found_reg;
                    out_slot_next  = found_reg ? tts_pkg::SLOT_W'(best_slot_reg) : '0;
                    out_id_next    = found_reg ? best_id_reg : '0;
                    out_comp_next  = found_reg && (best_rem_reg == tts_pkg::RUN_W'(1));
                    out_time_next  = now_reg;
                    state_next     = tts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_mode_reg <= tts_pkg::MODE_PRIORITY;
            task_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tts_pkg::CFG_SCHED_MODE:
                begin
                    sched_mode_reg <= cfg_data[tts_pkg::MODE_W-1:0];
                end
                tts_pkg::CFG_TASK_COUNT:
                begin
                    task_count_reg <= cfg_data[tts_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    sched_mode_reg <= sched_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tts_pkg::ST_IDLE;
            time_reg      <= '0;
            rot_reg       <= '0;
            iss_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            rot_reg       <= rot_next;
            iss_reg       <= iss_next;
            pend_vld_reg  <= pend_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        n_reg         <= n_next;
        addr_reg      <= addr_next;
        pend_slot_reg <= pend_slot_next;
        now_reg       <= now_next;
        best_key_reg  <= best_key_next;
        best_slot_reg <= best_slot_next;
        best_id_reg   <= best_id_next;
        best_rem_reg  <= best_rem_next;
        out_exec_reg  <= out_exec_next;
        out_slot_reg  <= out_slot_next;
        out_id_reg    <= out_id_next;
        out_comp_reg  <= out_comp_next;
        out_time_reg  <= out_time_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.executed    = out_exec_reg;
    assign result_out.chosen_slot = out_slot_reg;
    assign result_out.chosen_id   = out_id_reg;
    assign result_out.completed   = out_comp_reg;
    assign result_out.tick_time   = out_time_reg;

endmodule
`default_nettype wire

// File: rtl/tts_task_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tts_task_store
// Task table: an entry memory, a remaining-time memory and per-entry valid
// bits so that never-loaded entries read as finished.
// ----------------------------------------------------------------------------
module tts_task_store #(
    parameter int MAX_TASKS = tts_pkg::MAX_TASKS,
    localparam int AW = $clog2(MAX_TASKS)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire tts_pkg::store_cmd_t         cmd,
    input  wire [AW-1:0]                     wr_addr,
    input  wire tts_pkg::task_info_t         wr_info,
    input  wire [tts_pkg::RUN_W-1:0]         wr_rem,
    input  wire [AW-1:0]                     rd_addr,
    output tts_pkg::task_info_t              rd_info,
    output logic [tts_pkg::RUN_W-1:0]        rd_rem
);

    tts_pkg::task_info_t             info_mem [MAX_TASKS];
    logic [tts_pkg::RUN_W-1:0]       rem_mem  [MAX_TASKS];
    logic [MAX_TASKS-1:0]            valid_reg;

    logic [tts_pkg::RUN_W-1:0]       rem_q_reg;
    logic                            rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.info_we)
        begin
            info_mem[wr_addr] <= wr_info;
        end
        if (cmd.rem_we)
        begin
            rem_mem[wr_addr] <= wr_rem;
        end
        rd_info   <= info_mem[rd_addr];
        rem_q_reg <= rem_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= valid_reg[rd_addr];
        end
    end

    // An entry that was never loaded counts as finished.
    assign rd_rem = rd_ok_reg ? rem_q_reg : '0;

endmodule
`default_nettype wire
